### src/asp_pkg.sv
// shared constants and helpers for the screen rectangle projection block
// no dependencies; imported by every module of the block
package asp_pkg;

  localparam int ROW_BITS  = 64;
  localparam int LANE_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;
  localparam int AXES      = 3;
  localparam int CORNERS   = 8;
  localparam int ROWS      = 3;
  localparam int IDX_BITS  = 2;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF  = 16;

  localparam logic [ROW_BITS-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_BITS-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_BITS-1:0] ROW_W_RST = 64'h1000_0000_0000_0000;

  typedef enum logic [IDX_BITS-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_W = 2'd2
  } reg_idx_e;

  // width of a projected component: exact sum, capped at 64 bits
  function automatic int dot_width(input int cw, input int kw);
    return (cw + kw + 2 > 64) ? 64 : cw + kw + 2;
  endfunction

endpackage

### src/asp_dot.sv
// projection dot products for all eight corners of a box, four stages
// depends on asp_pkg
module asp_dot #(
  parameter int CW = 32,
  parameter int KW = 16
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [CW-1:0]                  lo_i   [asp_pkg::AXES],
  input  logic signed [CW-1:0]                  hi_i   [asp_pkg::AXES],
  input  logic [asp_pkg::ROW_BITS-1:0]          rows_i [asp_pkg::ROWS],
  output logic signed [asp_pkg::dot_width(CW, KW)-1:0]
                                                pd_o   [asp_pkg::CORNERS][asp_pkg::ROWS]
);
  import asp_pkg::*;

  localparam int DW = dot_width(CW, KW);
  localparam int PW = CW + KW;
  localparam int TW = KW + FRAC_BITS;

  logic signed [KW-1:0] k [ROWS][LANES];
  logic signed [PW-1:0] plo_q [ROWS][AXES];
  logic signed [PW-1:0] phi_q [ROWS][AXES];
  logic signed [TW-1:0] t3_q [ROWS];
  logic signed [TW-1:0] t3b_q [ROWS];
  logic signed [TW-1:0] t3c_q [ROWS];
  logic signed [PW-1:0] e2_q [CORNERS][ROWS];
  logic signed [DW-1:0] a1_q [CORNERS][ROWS];
  logic signed [DW-1:0] a2_q [CORNERS][ROWS];

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return s[DW-1:0];
  endfunction

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int i = 0; i < LANES; i++) begin
        k[r][i] = rows_i[r][LANE_BITS*i +: KW];
      end
    end
  end

  // products: only two coordinate values per axis, so 18 multipliers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int i = 0; i < AXES; i++) begin
          plo_q[r][i] <= PW'(k[r][i] * lo_i[i]);
          phi_q[r][i] <= PW'(k[r][i] * hi_i[i]);
        end
        t3_q[r] <= {k[r][3], {FRAC_BITS{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < CORNERS; c++) begin
        for (int r = 0; r < ROWS; r++) begin
          a1_q[c][r] <= sat_add(DW'(c[0] ? phi_q[r][0] : plo_q[r][0]),
                                DW'(c[1] ? phi_q[r][1] : plo_q[r][1]));
          e2_q[c][r] <= c[2] ? phi_q[r][2] : plo_q[r][2];
          a2_q[c][r] <= sat_add(a1_q[c][r], DW'(e2_q[c][r]));
          pd_o[c][r] <= sat_add(a2_q[c][r], DW'(t3c_q[r]));
        end
      end
      for (int r = 0; r < ROWS; r++) begin
        t3b_q[r] <= t3_q[r];
        t3c_q[r] <= t3b_q[r];
      end
    end
  end

endmodule

### src/asp_div.sv
// pipelined restoring divider, one quotient bit per stage, q16 saturated result
// depends on asp_pkg
module asp_div #(
  parameter int CW = 32,
  parameter int KW = 16
) (
  input  logic                                         clk_i,
  input  logic                                         en_i,
  input  logic signed [asp_pkg::dot_width(CW, KW)-1:0] num_i,
  input  logic signed [asp_pkg::dot_width(CW, KW)-1:0] den_i,
  output logic signed [CW-1:0]                         q_o,
  output logic                                         bad_o
);
  import asp_pkg::*;

  localparam int DW = dot_width(CW, KW);
  localparam int NW = DW + FRAC_BITS;
  localparam int HW = NW - CW;

  logic          neg;
  logic [DW-1:0] mag;
  logic [NW-1:0] nfull;
  logic [DW-1:0] nhi;
  logic [DW-1:0] dpos;
  logic          ovf;

  logic [DW-1:0] r_q   [CW+1];
  logic [CW-1:0] nl_q  [CW+1];
  logic [CW-1:0] q_q   [CW+1];
  logic [DW-1:0] d_q   [CW+1];
  logic          neg_q [CW+1];
  logic          ovf_q [CW+1];
  logic          bad_q [CW+1];

  always_comb begin
    neg   = num_i[DW-1];
    mag   = neg ? (~num_i + 1'b1) : num_i;
    nfull = {mag, {FRAC_BITS{1'b0}}};
    nhi   = DW'(nfull[NW-1 -: HW]);
    dpos  = {1'b0, den_i[DW-2:0]};
    // quotient would need more than CW bits
    ovf   = nhi >= dpos;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= ovf ? '0 : nhi;
      nl_q[0]  <= nfull[CW-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= dpos;
      neg_q[0] <= neg;
      ovf_q[0] <= ovf;
      bad_q[0] <= den_i[DW-1] | (den_i == '0);
    end
  end

  for (genvar s = 0; s < CW; s++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;
    always_comb begin
      r2   = {r_q[s], nl_q[s][CW-1]};
      diff = r2 - {1'b0, d_q[s]};
      ge   = r2 >= {1'b0, d_q[s]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]   <= ge ? diff[DW-1:0] : r2[DW-1:0];
        nl_q[s+1]  <= nl_q[s] << 1;
        q_q[s+1]   <= {q_q[s][CW-2:0], ge};
        d_q[s+1]   <= d_q[s];
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
        bad_q[s+1] <= bad_q[s];
      end
    end
  end

  logic [CW-1:0] lim;
  logic [CW-1:0] qs;

  always_comb begin
    lim = neg_q[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    qs  = (ovf_q[CW] || (q_q[CW] > lim)) ? lim : q_q[CW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o   <= neg_q[CW] ? (~qs + 1'b1) : qs;
      bad_o <= bad_q[CW];
    end
  end

endmodule

### src/asp_reduce.sv
// registered min/max tree over the eight projected corners, three levels
// depends on asp_pkg
module asp_reduce #(
  parameter int CW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] sx_i  [asp_pkg::CORNERS],
  input  logic signed [CW-1:0] sy_i  [asp_pkg::CORNERS],
  input  logic                 bad_i [asp_pkg::CORNERS],
  output logic signed [CW-1:0] min_x_o,
  output logic signed [CW-1:0] min_y_o,
  output logic signed [CW-1:0] max_x_o,
  output logic signed [CW-1:0] max_y_o,
  output logic                 bad_o
);
  import asp_pkg::*;

  logic signed [CW-1:0] mnx1_q [4], mxx1_q [4], mny1_q [4], mxy1_q [4];
  logic                 bad1_q [4];
  logic signed [CW-1:0] mnx2_q [2], mxx2_q [2], mny2_q [2], mxy2_q [2];
  logic                 bad2_q [2];

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b > a) ? b : a;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        mnx1_q[j] <= smin(sx_i[2*j], sx_i[2*j+1]);
        mxx1_q[j] <= smax(sx_i[2*j], sx_i[2*j+1]);
        mny1_q[j] <= smin(sy_i[2*j], sy_i[2*j+1]);
        mxy1_q[j] <= smax(sy_i[2*j], sy_i[2*j+1]);
        bad1_q[j] <= bad_i[2*j] | bad_i[2*j+1];
      end
      for (int j = 0; j < 2; j++) begin
        mnx2_q[j] <= smin(mnx1_q[2*j], mnx1_q[2*j+1]);
        mxx2_q[j] <= smax(mxx1_q[2*j], mxx1_q[2*j+1]);
        mny2_q[j] <= smin(mny1_q[2*j], mny1_q[2*j+1]);
        mxy2_q[j] <= smax(mxy1_q[2*j], mxy1_q[2*j+1]);
        bad2_q[j] <= bad1_q[2*j] | bad1_q[2*j+1];
      end
      // a bad w anywhere clears the rectangle
      min_x_o <= (bad2_q[0] | bad2_q[1]) ? '0 : smin(mnx2_q[0], mnx2_q[1]);
      max_x_o <= (bad2_q[0] | bad2_q[1]) ? '0 : smax(mxx2_q[0], mxx2_q[1]);
      min_y_o <= (bad2_q[0] | bad2_q[1]) ? '0 : smin(mny2_q[0], mny2_q[1]);
      max_y_o <= (bad2_q[0] | bad2_q[1]) ? '0 : smax(mxy2_q[0], mxy2_q[1]);
      bad_o   <= bad2_q[0] | bad2_q[1];
    end
  end

endmodule

### src/aabb_screen_rect_projection.sv
// top level: screen rectangle of a projected box; input skid, projection rows,
// dot product, divider and min/max tree; depends on asp_pkg, asp_dot, asp_div, asp_reduce
//
//  channel | handshake             | payload
//  in      | in_valid_i/in_stall_o | box_min_x_i .. box_max_z_i
//  out     | out_valid_o/out_stall_i | rect_min_x_o .. rect_max_y_o, w_invalid_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one box per cycle unless an output stall freezes the pipeline; the divider
// resolves one quotient bit per stage for sixteen quotients in parallel.
// reset clears valid bits, the skid slot and loads the identity projection rows.
// an output stall freezes the whole pipeline; one item lands in the input skid
// slot, so in_stall_o is a register and never follows out_stall_i in the same cycle.
module aabb_screen_rect_projection #(
  parameter int COORD_WIDTH = asp_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = asp_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] rect_min_x_o,
  output logic signed [COORD_WIDTH-1:0] rect_min_y_o,
  output logic signed [COORD_WIDTH-1:0] rect_max_x_o,
  output logic signed [COORD_WIDTH-1:0] rect_max_y_o,
  output logic                          w_invalid_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [asp_pkg::IDX_BITS-1:0]  cfg_index_i,
  input  logic [asp_pkg::ROW_BITS-1:0]  cfg_data_i
);
  import asp_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = dot_width(COORD_WIDTH, COEF_WIDTH);
  localparam int LAT = CW + 9;

  logic [ROW_BITS-1:0] rows_q [ROWS];

  logic                 skid_vld_q;
  logic signed [CW-1:0] skid_lo_q [AXES];
  logic signed [CW-1:0] skid_hi_q [AXES];
  logic signed [CW-1:0] in_lo [AXES];
  logic signed [CW-1:0] in_hi [AXES];
  logic signed [CW-1:0] src_lo [AXES];
  logic signed [CW-1:0] src_hi [AXES];
  logic                 src_vld;
  logic                 en;
  logic [LAT-1:0]       vld_q;

  logic signed [DW-1:0] pd [CORNERS][ROWS];
  logic signed [CW-1:0] sx [CORNERS];
  logic signed [CW-1:0] sy [CORNERS];
  logic                 bad [CORNERS];
  logic                 bad_y [CORNERS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[REG_ROW_X] <= ROW_X_RST;
      rows_q[REG_ROW_Y] <= ROW_Y_RST;
      rows_q[REG_ROW_W] <= ROW_W_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_X: rows_q[REG_ROW_X] <= cfg_data_i;
        REG_ROW_Y: rows_q[REG_ROW_Y] <= cfg_data_i;
        REG_ROW_W: rows_q[REG_ROW_W] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_lo = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign in_hi = '{box_max_x_i, box_max_y_i, box_max_z_i};

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = skid_vld_q;
  assign src_vld    = skid_vld_q | in_valid_i;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      src_lo[i] = skid_vld_q ? skid_lo_q[i] : in_lo[i];
      src_hi[i] = skid_vld_q ? skid_hi_q[i] : in_hi[i];
    end
  end

  // skid slot catches an item taken while the pipeline is frozen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (in_valid_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_vld_q) begin
      skid_lo_q <= in_lo;
      skid_hi_q <= in_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], src_vld};
    end
  end

  assign out_valid_o = vld_q[LAT-1];

  asp_dot #(.CW(CW), .KW(COEF_WIDTH)) u_dot (
    .clk_i  (clk_i),
    .en_i   (en),
    .lo_i   (src_lo),
    .hi_i   (src_hi),
    .rows_i (rows_q),
    .pd_o   (pd)
  );

  for (genvar c = 0; c < CORNERS; c++) begin : g_corner
    asp_div #(.CW(CW), .KW(COEF_WIDTH)) u_div_x (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (pd[c][REG_ROW_X]),
      .den_i (pd[c][REG_ROW_W]),
      .q_o   (sx[c]),
      .bad_o (bad[c])
    );
    asp_div #(.CW(CW), .KW(COEF_WIDTH)) u_div_y (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (pd[c][REG_ROW_Y]),
      .den_i (pd[c][REG_ROW_W]),
      .q_o   (sy[c]),
      .bad_o (bad_y[c])
    );
  end

  logic bad_any [CORNERS];
  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      bad_any[c] = bad[c] | bad_y[c];
    end
  end

  asp_reduce #(.CW(CW)) u_reduce (
    .clk_i   (clk_i),
    .en_i    (en),
    .sx_i    (sx),
    .sy_i    (sy),
    .bad_i   (bad_any),
    .min_x_o (rect_min_x_o),
    .min_y_o (rect_min_y_o),
    .max_x_o (rect_max_x_o),
    .max_y_o (rect_max_y_o),
    .bad_o   (w_invalid_o)
  );

endmodule
